[rtl/core/queue_machine_executor_assert.svh]
// Assertion macros shared by the queue machine executor checkers.
`ifndef QUEUE_MACHINE_EXECUTOR_ASSERT_SVH
`define QUEUE_MACHINE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QME_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/qme_pkg.sv]
// Shared types and constants of the queue machine executor.
package qme_pkg;

    // Field widths fixed by the instruction and result formats
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int PTR_W     = 11;
    localparam int IN_USED_W = CMD_W + WORD_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;

    // Largest program the pointer check accepts
    localparam logic [PTR_W-1:0] PROG_CAPACITY = 11'd1024;

    // Opcodes
    localparam logic [CMD_W-1:0] CMD_NOP     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_HALT    = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PTR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd5;

    // Step outcome handed from the execute stage to the output side
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PTR_W-1:0]    next_pointer;
        logic                stopped;
    } step_ctl_t;

endpackage

[rtl/core/qme_queue_store.sv]
// Word storage of the queue: one write port, two registered read ports with write bypass.
module qme_queue_store import qme_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int AW = $clog2(QUEUE_DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr0,
    input  logic [AW-1:0]     raddr1,
    output logic [WORD_W-1:0] rdata0,
    output logic [WORD_W-1:0] rdata1
);

    logic [WORD_W-1:0] mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] rdata0_reg;
    logic [WORD_W-1:0] rdata1_reg;

    // Write the tail entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read both head entries; forward a word written at the same edge
    always_ff @(posedge clk)
    begin
        rdata0_reg <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
        rdata1_reg <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

[rtl/core/qme_exec.sv]
// Execute stage: queue pointers, instruction pointer, stop flag and the step result register.
module qme_exec import qme_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [PTR_W-1:0]  cfg_data,
    input  logic              fire,
    input  logic              post_take,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [WORD_W-1:0] operand,
    input  logic [WORD_W-1:0] head_word,
    input  logic [WORD_W-1:0] second_word,
    output logic              we,
    output logic [AW-1:0]     waddr,
    output logic [WORD_W-1:0] wdata,
    output logic [AW-1:0]     raddr0,
    output logic [AW-1:0]     raddr1,
    output logic              post_valid,
    output step_ctl_t         post_ctl,
    output logic [CW-1:0]     post_count
);

    localparam logic [CW-1:0] DepthCount = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LastIndex  = AW'(QUEUE_DEPTH - 1);

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             halt_reg, halt_next;
    logic [PTR_W-1:0] plen_reg, plen_next;
    logic             post_valid_reg, post_valid_next;
    step_ctl_t        post_ctl_reg;
    logic [CW-1:0]    post_count_reg;

    logic             push, pop_one, pop_two, done, halt_set;
    logic [STATUS_W-1:0] status;
    logic [PTR_W-1:0] ptr_adv;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        wrap_inc = (idx == LastIndex) ? '0 : idx + 1'b1;
    endfunction

    // Decode the instruction against the current queue state
    always_comb
    begin
        push     = 1'b0;
        pop_one  = 1'b0;
        pop_two  = 1'b0;
        done     = 1'b0;
        halt_set = 1'b0;
        status   = ST_OK;
        if (halt_reg)
        begin
            status = ST_REFUSED;
        end
        else
        begin
            case (cmd)
                CMD_NOP:
                begin
                    done = 1'b1;
                end
                CMD_ENQUEUE:
                begin
                    if (count_reg == DepthCount)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        push = 1'b1;
                        done = 1'b1;
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (count_reg == '0)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop_one = 1'b1;
                        done    = 1'b1;
                    end
                end
                CMD_ADD:
                begin
                    if (count_reg < CW'(2))
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        pop_two = 1'b1;
                        push    = 1'b1;
                        done    = 1'b1;
                    end
                end
                CMD_HALT:
                begin
                    halt_set = 1'b1;
                end
                default:
                begin
                    status = ST_ILLEGAL;
                end
            endcase
        end

        // Advance the pointer and check it against the program bound
        ptr_adv  = ptr_reg + 1'b1;
        ptr_next = done ? ptr_adv : ptr_reg;
        if (done && (ptr_adv >= plen_reg))
        begin
            status = ST_BAD_PTR;
        end
        halt_next = halt_reg | halt_set | (status != ST_OK);
    end

    // Next queue pointers and fill count
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop_two)
        begin
            head_next = wrap_inc(wrap_inc(head_reg));
        end
        else if (pop_one)
        begin
            head_next = wrap_inc(head_reg);
        end
        if (push)
        begin
            tail_next = wrap_inc(tail_reg);
        end
        if (pop_one || (push && pop_two))
        begin
            count_next = count_reg - 1'b1;
        end
        else if (push)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Storage access: tail write, reads at the head the next step will see
    assign we     = fire && push;
    assign waddr  = tail_reg;
    assign wdata  = (cmd == CMD_ADD) ? (head_word + second_word) : operand;
    assign raddr0 = fire ? head_next : head_reg;
    assign raddr1 = wrap_inc(raddr0);

    // Saturate the program length on write
    assign plen_next = (cfg_data > PROG_CAPACITY) ? PROG_CAPACITY : cfg_data;

    // Result register holds until the output side takes it
    assign post_valid_next = fire ? 1'b1 : (post_take ? 1'b0 : post_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            halt_reg       <= 1'b0;
            plen_reg       <= '0;
            post_valid_reg <= 1'b0;
        end
        else
        begin
            post_valid_reg <= post_valid_next;
            if (cfg_write)
            begin
                plen_reg <= plen_next;
            end
            if (fire)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                ptr_reg   <= ptr_next;
                halt_reg  <= halt_next;
            end
        end
    end

    // Capture the step outcome
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            post_ctl_reg.status       <= status;
            post_ctl_reg.next_pointer <= ptr_next;
            post_ctl_reg.stopped      <= halt_next;
            post_count_reg            <= count_next;
        end
    end

    assign post_valid = post_valid_reg;
    assign post_ctl   = post_ctl_reg;
    assign post_count = post_count_reg;

endmodule

[rtl/core/qme_out_buf.sv]
// Two-entry output buffer that decouples the result stream from receiver stalls.
module qme_out_buf #(
    parameter int DATA_W = 88
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic [1:0]        cnt_reg, cnt_next;
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [DATA_W-1:0] buf_reg [2];
    logic              pop;

    assign pop      = m_tvalid && m_tready;
    assign space    = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/core/queue_machine_executor.sv]
// Queue machine executor: one instruction per transfer on a bounded FIFO of 64-bit words.
//
// Usage: each transfer on the s_ channel is one instruction (opcode and operand).
// Every instruction yields exactly one transfer on the m_ channel carrying the status,
// the instruction pointer, the word now at the queue head, the fill count and the
// stop flag. The cfg channel writes the program length (always ready); write it
// only while no instruction is in flight.
// A result passes the input register, the execute stage and the output buffer in
// turn. Throughput: one instruction per cycle while the receiver does not stall,
// set by the execute stage and the two read ports of the queue storage.
// Reset empties the queue, clears the pointer, the program length and the stop flag.
// After an error or HALT every later instruction is still taken but answered as
// refused, until reset.
// A stalled receiver fills the two-entry output buffer; the execute stage and then
// s_tready hold back until space frees, and no result is lost.
module queue_machine_executor import qme_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_USED_W = STATUS_W + PTR_W + WORD_W + CW + 1,
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [PTR_W-1:0]       cfg_data,     // program_length
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,      // cmd, operand, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata       // status, next_pointer, head_value,
                                                 // queue_count, stopped, zero pad
);

    logic              in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] operand_reg;
    logic              s_accept;
    logic              fire;
    logic              post_take;
    logic              out_space;
    logic              we;
    logic [AW-1:0]     waddr, raddr0, raddr1;
    logic [WORD_W-1:0] wdata, head_word, second_word;
    logic              post_valid;
    step_ctl_t         post_ctl;
    logic [CW-1:0]     post_count;
    logic [WORD_W-1:0] head_value;
    logic [OUT_USED_W-1:0]  out_used;
    logic [OUT_TDATA_W-1:0] out_word;

    assign cfg_ready = 1'b1;

    // Input register: take a new instruction while it is empty or the current one moves on
    assign post_take = post_valid && out_space;
    assign fire      = in_valid_reg && (!post_valid || post_take);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;
    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg     <= s_tdata[CMD_W-1:0];
            operand_reg <= s_tdata[CMD_W +: WORD_W];
        end
    end

    qme_queue_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (head_word),
        .rdata1 (second_word)
    );

    qme_exec #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .fire        (fire),
        .post_take   (post_take),
        .cmd         (cmd_reg),
        .operand     (operand_reg),
        .head_word   (head_word),
        .second_word (second_word),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr0      (raddr0),
        .raddr1      (raddr1),
        .post_valid  (post_valid),
        .post_ctl    (post_ctl),
        .post_count  (post_count)
    );

    // Head word read after the step lands; empty queue reads as zero
    assign head_value = (post_count != '0) ? head_word : '0;

    // Pack the result, first field in the lowest bits
    assign out_used = {post_ctl.stopped, post_count, head_value,
                       post_ctl.next_pointer, post_ctl.status};
    assign out_word = OUT_TDATA_W'(out_used);

    qme_out_buf #(
        .DATA_W(OUT_TDATA_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (post_take),
        .push_data (out_word),
        .space     (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/core/qme_port_checker.sv]
// Port-level checker of the queue machine executor, bound to the top level.
`include "queue_machine_executor_assert.svh"

module qme_port_checker import qme_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_USED_W = STATUS_W + PTR_W + WORD_W + CW + 1,
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8,
    localparam int HEAD_LSB = STATUS_W + PTR_W,
    localparam int COUNT_LSB = HEAD_LSB + WORD_W,
    localparam int STOP_BIT = COUNT_LSB + CW
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                seen_stop_reg;
    logic                out_xfer;
    logic [STATUS_W-1:0] out_status;
    logic [WORD_W-1:0]   out_head;
    logic [CW-1:0]       out_count;
    logic                out_stopped;

    assign out_xfer    = m_tvalid && m_tready;
    assign out_status  = m_tdata[STATUS_W-1:0];
    assign out_head    = m_tdata[HEAD_LSB +: WORD_W];
    assign out_count   = m_tdata[COUNT_LSB +: CW];
    assign out_stopped = m_tdata[STOP_BIT];

    // Remember that a stopped result has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_stop_reg <= 1'b0;
        end
        else if (out_xfer && out_stopped)
        begin
            seen_stop_reg <= 1'b1;
        end
    end

    `QME_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `QME_ASSERT_IMPLIES(a_error_stops, clk, rst_n, out_xfer && (out_status != ST_OK), out_stopped, "error result without stop flag")
    `QME_ASSERT_IMPLIES(a_refused_after_stop, clk, rst_n, out_xfer && seen_stop_reg, (out_status == ST_REFUSED) && out_stopped, "instruction executed after stop")
    `QME_ASSERT_IMPLIES(a_empty_head_zero, clk, rst_n, out_xfer && (out_count == '0), out_head == '0, "empty queue with nonzero head")

endmodule

bind queue_machine_executor qme_port_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
